// File: design/tzpd_pkg.sv
// Shared widths, types, register codes and reset values of the zone passage detector.
package tzpd_pkg;

    // Field widths.
    localparam int DIST_W     = 16;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 20;
    localparam int HITS_W     = 5;
    localparam int POS_W      = 4;
    localparam int TOTAL_W    = 16;
    localparam int WIN_W      = 16;
    localparam int AVG_W      = 16;
    localparam int BANDS      = 3;

    // Stream and configuration port widths.
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Band positions.
    localparam int BAND_NEAR  = 0;
    localparam int BAND_MID   = 1;
    localparam int BAND_FAR   = 2;

    // Configuration register reset values.
    localparam logic [DIST_W-1:0] RST_NEAR_LIMIT = 16'd500;
    localparam logic [DIST_W-1:0] RST_MID_LIMIT  = 16'd1000;
    localparam logic [DIST_W-1:0] RST_FAR_LIMIT  = 16'd1500;
    localparam logic [HITS_W-1:0] RST_ARM_HITS   = 5'd4;
    localparam logic [HITS_W-1:0] RST_CLEAR_HITS = 5'd1;
    localparam logic [WIN_W-1:0]  RST_WINDOW     = 16'd1500;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_LIMIT = 3'd0,
        CFG_MID_LIMIT  = 3'd1,
        CFG_FAR_LIMIT  = 3'd2,
        CFG_ARM_HITS   = 3'd3,
        CFG_CLEAR_HITS = 3'd4,
        CFG_WINDOW     = 3'd5
    } cfg_index_t;

    typedef logic [HITS_W-1:0] hits_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [DIST_W-1:0] near_limit;
        logic [DIST_W-1:0] mid_limit;
        logic [DIST_W-1:0] far_limit;
        hits_t             arm_hits;
        hits_t             clear_hits;
        logic [WIN_W-1:0]  window;
    } cfg_t;

    // One completed scan, handed from the front end to the back end.
    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        hits_t [BANDS-1:0]       hits;
        logic [TIME_W-1:0]       now;
    } scan_rec_t;

endpackage

// File: design/tzpd_front.sv
// Front end: accumulates zone samples and emits one record per completed scan.
module tzpd_front
    import tzpd_pkg::*;
#(
    parameter int ZONES = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DIST_W-1:0] distance_mm,
    input  logic [TIME_W-1:0] time_ms,
    input  logic              q_full,
    output logic              push,
    output scan_rec_t         rec
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    hits_t [BANDS-1:0] hits_reg, hits_next;

    logic [SUM_W-1:0]  sum_upd;
    hits_t [BANDS-1:0] hits_upd;
    logic [DIST_W-1:0] limit [BANDS];
    logic              last_zone;
    logic              accept;

    // Band limits in band order.
    assign limit[BAND_NEAR] = cfg.near_limit;
    assign limit[BAND_MID]  = cfg.mid_limit;
    assign limit[BAND_FAR]  = cfg.far_limit;

    // Only the scan-end sample needs room in the queue.
    always_comb
    begin
        last_zone = (pos_reg == POS_W'(ZONES - 1));
        in_ready  = !(last_zone && q_full);
        accept    = in_valid && in_ready;
        push      = accept && last_zone;

        sum_upd = sum_reg + SUM_W'(distance_mm);
        for (int b = 0; b < BANDS; b++)
        begin
            hits_upd[b] = hits_reg[b] + HITS_W'(distance_mm < limit[b]);
        end

        rec.sum  = sum_upd;
        rec.hits = hits_upd;
        rec.now  = time_ms;

        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hits_next = hits_reg;
        if (accept)
        begin
            if (last_zone)
            begin
                pos_next  = '0;
                sum_next  = '0;
                hits_next = '0;
            end
            else
            begin
                pos_next  = pos_reg + POS_W'(1);
                sum_next  = sum_upd;
                hits_next = hits_upd;
            end
        end
    end

    // Scan accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            hits_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            hits_reg <= hits_next;
        end
    end

endmodule

// File: design/tzpd_queue.sv
// Two-entry register queue of scan records between the front and back ends.
module tzpd_queue
    import tzpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scan_rec_t push_rec,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output scan_rec_t pop_rec
);

    scan_rec_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Status and pointer updates.
    always_comb
    begin
        full    = (count_reg == 2'd2);
        valid   = (count_reg != 2'd0);
        pop_rec = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: design/tzpd_back.sv
// Back end: runs the band timers, forms the mean distance and holds the result register.
module tzpd_back
    import tzpd_pkg::*;
#(
    parameter int ZONES = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  scan_rec_t          rec,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [AVG_W-1:0]   avg_distance,
    output logic [BANDS-1:0]   band_event,
    output logic [TOTAL_W-1:0] band_total [BANDS]
);

    // Exact floor division by ZONES through a rounded-up reciprocal.
    localparam int          DIV_SHIFT = SUM_W + $clog2(ZONES);
    localparam int          RECIP_W   = SUM_W + 1;
    localparam int unsigned DIV_RECIP = ((32'd1 << DIV_SHIFT) + ZONES - 1) / ZONES;

    logic                     armed_reg [BANDS];
    logic                     armed_next [BANDS];
    logic [TIME_W-1:0]        start_reg [BANDS];
    logic [TIME_W-1:0]        start_next [BANDS];
    logic [TOTAL_W-1:0]       total_reg [BANDS];
    logic [TOTAL_W-1:0]       total_next [BANDS];
    logic                     valid_reg, valid_next;
    logic [AVG_W-1:0]         avg_reg;
    logic [BANDS-1:0]         event_reg;

    logic [SUM_W+RECIP_W-1:0] prod;
    logic [AVG_W-1:0]         avg_calc;
    logic [BANDS-1:0]         event_calc;
    logic                     armed_now;
    logic [TIME_W-1:0]        start_now;
    logic [TIME_W-1:0]        elapsed;
    logic                     in_window;

    // Mean distance of the scan.
    always_comb
    begin
        prod     = {{RECIP_W{1'b0}}, rec.sum} * (SUM_W + RECIP_W)'(DIV_RECIP);
        avg_calc = AVG_W'(prod >> DIV_SHIFT);
    end

    // Band timers: arm first, then test for a detection or an expired window.
    always_comb
    begin
        pop        = q_valid && (!valid_reg || out_ready);
        valid_next = pop || (valid_reg && !out_ready);
        armed_now  = 1'b0;
        start_now  = '0;
        elapsed    = '0;
        in_window  = 1'b0;
        for (int b = 0; b < BANDS; b++)
        begin
            armed_now = armed_reg[b];
            start_now = start_reg[b];
            if (!armed_reg[b] && (rec.hits[b] >= cfg.arm_hits))
            begin
                armed_now = 1'b1;
                start_now = rec.now;
            end
            elapsed       = rec.now - start_now;
            in_window     = (elapsed <= TIME_W'(cfg.window));
            event_calc[b] = armed_now && in_window && (rec.hits[b] <= cfg.clear_hits);

            armed_next[b] = armed_reg[b];
            start_next[b] = start_reg[b];
            total_next[b] = total_reg[b];
            if (pop)
            begin
                start_next[b] = start_now;
                if (event_calc[b])
                begin
                    armed_next[b] = 1'b0;
                    total_next[b] = total_reg[b] + TOTAL_W'(1);
                end
                else if (!in_window)
                begin
                    armed_next[b] = 1'b0;
                end
                else
                begin
                    armed_next[b] = armed_now;
                end
            end
        end
    end

    // Band state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int b = 0; b < BANDS; b++)
            begin
                armed_reg[b] <= 1'b0;
                start_reg[b] <= '0;
                total_reg[b] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int b = 0; b < BANDS; b++)
            begin
                armed_reg[b] <= armed_next[b];
                start_reg[b] <= start_next[b];
                total_reg[b] <= total_next[b];
            end
        end
    end

    // Result payload, loaded when a scan record is taken.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            avg_reg   <= avg_calc;
            event_reg <= event_calc;
        end
    end

    // The running totals after a pop belong to the result just loaded.
    assign out_valid    = valid_reg;
    assign avg_distance = avg_reg;
    assign band_event   = event_reg;
    assign band_total   = total_reg;

endmodule

// File: design/tof_zone_passage_detector.sv
// Top level of the zone passage detector: configuration registers and stream ports.
//
// Channel  Direction  Handshake            Content
// s_       in         s_tvalid / s_tready  one zone sample (distance, timestamp)
// m_       out        m_tvalid / m_tready  one result per completed scan
// cfg_     in         cfg_valid / cfg_ready register index and write data
//
// The block takes one sample per cycle while s_tready is high. A scan-end sample enters a
// two-entry record queue; the back end takes a record once its result register is empty
// or being read, and registers the result for the m_ channel.
// Reset clears the scan accumulators, band timers, totals and queue, and loads the
// register defaults. s_tready drops only on a scan-end sample while the queue is full.
module tof_zone_passage_detector
    import tzpd_pkg::*;
#(
    parameter int ZONES = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: distance_mm [15:0], time_ms [47:16]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // m_tdata: avg_distance [15:0], near_event [16], mid_event [17], far_event [18],
    // near_total [34:19], mid_total [50:35], far_total [66:51], zero [71:67]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    scan_rec_t          push_rec;
    scan_rec_t          pop_rec;
    logic [AVG_W-1:0]   avg_distance;
    logic [BANDS-1:0]   band_event;
    logic [TOTAL_W-1:0] band_total [BANDS];

    // Register writes are always taken; an index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit <= RST_NEAR_LIMIT;
            cfg_reg.mid_limit  <= RST_MID_LIMIT;
            cfg_reg.far_limit  <= RST_FAR_LIMIT;
            cfg_reg.arm_hits   <= RST_ARM_HITS;
            cfg_reg.clear_hits <= RST_CLEAR_HITS;
            cfg_reg.window     <= RST_WINDOW;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_NEAR_LIMIT: cfg_reg.near_limit <= cfg_data;
                CFG_MID_LIMIT:  cfg_reg.mid_limit  <= cfg_data;
                CFG_FAR_LIMIT:  cfg_reg.far_limit  <= cfg_data;
                CFG_ARM_HITS:   cfg_reg.arm_hits   <= cfg_data[HITS_W-1:0];
                CFG_CLEAR_HITS: cfg_reg.clear_hits <= cfg_data[HITS_W-1:0];
                CFG_WINDOW:     cfg_reg.window     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sample accumulation.
    tzpd_front #(
        .ZONES (ZONES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .distance_mm (s_tdata[DIST_W-1:0]),
        .time_ms     (s_tdata[DIST_W+TIME_W-1:DIST_W]),
        .q_full      (q_full),
        .push        (push),
        .rec         (push_rec)
    );

    // Scan record queue.
    tzpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .pop_rec  (pop_rec)
    );

    // Band timers and result register.
    tzpd_back #(
        .ZONES (ZONES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .rec          (pop_rec),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .avg_distance (avg_distance),
        .band_event   (band_event),
        .band_total   (band_total)
    );

    // Result packing, first field in the lowest bits.
    assign m_tdata = {5'b0,
                      band_total[BAND_FAR], band_total[BAND_MID], band_total[BAND_NEAR],
                      band_event[BAND_FAR], band_event[BAND_MID], band_event[BAND_NEAR],
                      avg_distance};

endmodule

// File: design/tzpd_checker.sv
// Port-level checker of the zone passage detector, bound to the top level.
module tzpd_checker
    import tzpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata
);

    logic                     have_prev_reg;
    logic [3*TOTAL_W-1:0]     prev_totals_reg;
    logic                     out_accept;

    assign out_accept = m_tvalid && m_tready;

    // Totals of the last delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg   <= 1'b0;
            prev_totals_reg <= '0;
        end
        else if (out_accept)
        begin
            have_prev_reg   <= 1'b1;
            prev_totals_reg <= m_tdata[66:19];
        end
    end

    // No result is offered in the cycle after reset is seen asserted.
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Padding bits above the last field stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[71:67] == 5'd0))
        else $error("result padding not zero");

    // Each running total advances exactly by its event flag from one result to the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && have_prev_reg |->
            (m_tdata[34:19] == prev_totals_reg[15:0] + 16'(m_tdata[16])) &&
            (m_tdata[50:35] == prev_totals_reg[31:16] + 16'(m_tdata[17])) &&
            (m_tdata[66:51] == prev_totals_reg[47:32] + 16'(m_tdata[18])))
        else $error("band total inconsistent with event flag");

endmodule

bind tof_zone_passage_detector tzpd_checker u_tzpd_checker (.*);

// File: dv/tof_zone_passage_detector_test.sv
// Self-checking testbench of the zone passage detector with a scan predictor and stream checks.
`timescale 1ns / 1ps

module tof_zone_passage_detector_test;
    import tzpd_pkg::*;

    localparam int SCAN_ZONES    = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int SCANS_PER_PHASE = 15;

    // Register indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // One zone sample, laid out as s_tdata.
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [DIST_W-1:0] distance_mm;
    } zone_sample_t;

    // One scan summary as the block reports it.
    typedef struct packed {
        logic [AVG_W-1:0]                  avg_distance;
        logic [BANDS-1:0]                  band_event;
        logic [BANDS-1:0][TOTAL_W-1:0]     band_total;
    } scan_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the configuration registers.
    logic [DIST_W-1:0]  lim_mm [BANDS];
    logic [HITS_W-1:0]  arm_level;
    logic [HITS_W-1:0]  clear_level;
    logic [WIN_W-1:0]   window_span;

    // Mirror of the scan accumulators and band timers.
    logic [POS_W-1:0]   zone_idx;
    logic [SUM_W-1:0]   dist_acc;
    logic [HITS_W-1:0]  hit_count   [BANDS];
    logic               timer_on    [BANDS];
    logic [TIME_W-1:0]  timer_start [BANDS];
    logic [TOTAL_W-1:0] pass_count  [BANDS];

    zone_sample_t zone_q [$];
    scan_result_t scan_expect_q [$];
    scan_result_t scan_outcome;
    scan_result_t seen;
    scan_result_t wanted;

    int          samples_queued = 0;
    int          samples_taken  = 0;
    int          scans_queued   = 0;
    int          fail_count     = 0;
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    int          step_ms        = 40;
    logic [31:0] stamp_ms       = '0;
    string       band_tag [BANDS] = '{"near", "mid", "far"};

    tof_zone_passage_detector #(
        .ZONES(SCAN_ZONES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("tof_zone_passage_detector verification failed");
        $finish;
    end

    // Folds one sample into the scan; at the scan end runs the band timers and
    // returns 1 with the summary the block should report.
    function automatic bit advance_scan(input zone_sample_t zs, output scan_result_t res);
        logic [TIME_W-1:0] elapsed;
        res = '0;
        dist_acc = dist_acc + SUM_W'(zs.distance_mm);
        for (int b = 0; b < BANDS; b++)
            if (zs.distance_mm < lim_mm[b])
                hit_count[b] = hit_count[b] + 1'b1;
        if (zone_idx != POS_W'(SCAN_ZONES - 1))
        begin
            zone_idx = zone_idx + 1'b1;
            return 1'b0;
        end
        res.avg_distance = AVG_W'(dist_acc / SCAN_ZONES);
        for (int b = 0; b < BANDS; b++)
        begin
            // The arm test comes first, so a band may arm and detect in one scan.
            if (!timer_on[b] && hit_count[b] >= arm_level)
            begin
                timer_on[b]    = 1'b1;
                timer_start[b] = zs.time_ms;
            end
            if (timer_on[b])
            begin
                elapsed = zs.time_ms - timer_start[b];
                if (elapsed <= TIME_W'(window_span) && hit_count[b] <= clear_level)
                begin
                    pass_count[b]     = pass_count[b] + 1'b1;
                    timer_on[b]       = 1'b0;
                    res.band_event[b] = 1'b1;
                end
                else if (elapsed > TIME_W'(window_span))
                    timer_on[b] = 1'b0;
            end
            res.band_total[b] = pass_count[b];
        end
        zone_idx = '0;
        dist_acc = '0;
        for (int b = 0; b < BANDS; b++)
            hit_count[b] = '0;
        return 1'b1;
    endfunction

    // Highest of the three band limits.
    function automatic int widest_limit();
        int top;
        top = 0;
        for (int b = 0; b < BANDS; b++)
            if (int'(lim_mm[b]) > top)
                top = int'(lim_mm[b]);
        return top;
    endfunction

    // Sample driver: launches queued samples and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (advance_scan(zone_sample_t'(s_tdata), scan_outcome))
                    scan_expect_q.push_back(scan_outcome);
                samples_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (zone_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= zone_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each scan summary with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.avg_distance = m_tdata[AVG_W-1:0];
                for (int b = 0; b < BANDS; b++)
                begin
                    seen.band_event[b] = m_tdata[AVG_W + b];
                    seen.band_total[b] = m_tdata[AVG_W + BANDS + b * TOTAL_W +: TOTAL_W];
                end
                if (scan_expect_q.size() == 0)
                begin
                    $error("scan result with no scan pending: m_tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    wanted = scan_expect_q.pop_front();
                    if (seen.avg_distance !== wanted.avg_distance)
                    begin
                        $error("avg_distance mismatch: expected %0d, actual %0d",
                               wanted.avg_distance, seen.avg_distance);
                        fail_count++;
                    end
                    for (int b = 0; b < BANDS; b++)
                    begin
                        if (seen.band_event[b] !== wanted.band_event[b])
                        begin
                            $error("%s_event mismatch: expected %0d, actual %0d", band_tag[b],
                                   wanted.band_event[b], seen.band_event[b]);
                            fail_count++;
                        end
                        if (seen.band_total[b] !== wanted.band_total[b])
                        begin
                            $error("%s_total mismatch: expected %0d, actual %0d", band_tag[b],
                                   wanted.band_total[b], seen.band_total[b]);
                            fail_count++;
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Writes one register and updates the mirror once the transaction completes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NEAR_LIMIT: lim_mm[BAND_NEAR] = DIST_W'(value);
            CFG_MID_LIMIT:  lim_mm[BAND_MID]  = DIST_W'(value);
            CFG_FAR_LIMIT:  lim_mm[BAND_FAR]  = DIST_W'(value);
            CFG_ARM_HITS:   arm_level   = HITS_W'(value);
            CFG_CLEAR_HITS: clear_level = HITS_W'(value);
            CFG_WINDOW:     window_span = WIN_W'(value);
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(input logic [DIST_W-1:0] zone_dist, input logic [TIME_W-1:0] stamp);
        zone_sample_t zs;
        zs.distance_mm = zone_dist;
        zs.time_ms     = stamp;
        zone_q.push_back(zs);
        samples_queued++;
    endtask

    // Queues one scan: an object of obj_zones adjacent zones near obj_mm over a
    // background beyond every limit, or all zones random when noisy is set.
    task automatic queue_scan(input int obj_zones, input int obj_mm, input bit noisy);
        int first;
        int bg_floor;
        int zone_mm;
        first    = $urandom_range(0, SCAN_ZONES - obj_zones);
        bg_floor = widest_limit();
        // Occasional time jumps, some far enough to expire an armed timer.
        if ($urandom_range(0, 19) == 0)
            stamp_ms = $urandom();
        else if ($urandom_range(0, 7) == 0)
            stamp_ms += $urandom_range(0, 2 * int'(window_span) + 2);
        for (int z = 0; z < SCAN_ZONES; z++)
        begin
            stamp_ms += $urandom_range(1, step_ms);
            if (noisy)
                zone_mm = $urandom_range(0, 65535);
            else if (z >= first && z < first + obj_zones)
            begin
                zone_mm = obj_mm + int'($urandom_range(0, 40));
                if (zone_mm > 65535)
                    zone_mm = 65535;
            end
            else
                zone_mm = $urandom_range(bg_floor, 65535);
            push_sample(DIST_W'(zone_mm), stamp_ms);
        end
        scans_queued++;
    endtask

    // Queues one passage: an empty scan, a few scans with the object present,
    // then scans where it has mostly left.
    task automatic queue_passage();
        int span_mm;
        int peak;
        int hold;
        int fade;
        span_mm = widest_limit() + 200;
        if (span_mm > 65535)
            span_mm = 65535;
        span_mm = $urandom_range(0, span_mm);
        peak    = $urandom_range(1, SCAN_ZONES);
        hold    = $urandom_range(1, 4);
        fade    = $urandom_range(1, 2);
        queue_scan(0, 0, 1'b0);
        repeat (hold)
            queue_scan(peak - int'($urandom_range(0, 1)), span_mm, 1'b0);
        repeat (fade)
            queue_scan($urandom_range(0, 2), span_mm, 1'b0);
    endtask

    // Waits until every sample is taken and every scan result has arrived.
    task automatic wait_idle();
        while (samples_taken != samples_queued || scan_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        int phase;
        // Register defaults and cleared state, as after reset.
        lim_mm[BAND_NEAR] = RST_NEAR_LIMIT;
        lim_mm[BAND_MID]  = RST_MID_LIMIT;
        lim_mm[BAND_FAR]  = RST_FAR_LIMIT;
        arm_level   = RST_ARM_HITS;
        clear_level = RST_CLEAR_HITS;
        window_span = RST_WINDOW;
        zone_idx    = '0;
        dist_acc    = '0;
        for (int b = 0; b < BANDS; b++)
        begin
            hit_count[b]   = '0;
            timer_on[b]    = 1'b0;
            timer_start[b] = '0;
            pass_count[b]  = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed scans on the reset settings: arm with all zones at zero, then
        // clear with all zones at full scale across a timestamp wrap.
        tx_idle_pct  = 6;
        rx_stall_pct = 84;
        for (int z = 0; z < SCAN_ZONES; z++)
            push_sample(16'h0000, 32'hFFFF_FF00);
        for (int z = 0; z < SCAN_ZONES; z++)
            push_sample(16'hFFFF, 32'h0000_0100);
        // Arm again, then a scan with distances on each side of every limit that
        // lands one millisecond past the window, so every timer expires.
        for (int z = 0; z < SCAN_ZONES; z++)
            push_sample(16'h0000, 32'h0000_1000);
        push_sample(16'd499,  32'h0000_1000 + 32'd1501);
        push_sample(16'd500,  32'h0000_1000 + 32'd1501);
        push_sample(16'd999,  32'h0000_1000 + 32'd1501);
        push_sample(16'd1000, 32'h0000_1000 + 32'd1501);
        push_sample(16'd1499, 32'h0000_1000 + 32'd1501);
        push_sample(16'd1500, 32'h0000_1000 + 32'd1501);
        wait_idle();
        stamp_ms = 32'h0000_2000;

        // Random phases, each with its own settings and pacing.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_NEAR_LIMIT, 0);
                    write_reg(CFG_MID_LIMIT, 65535);
                    write_reg(CFG_FAR_LIMIT, $urandom_range(0, 3000));
                    write_reg(CFG_ARM_HITS, 32'(RST_ARM_HITS));
                    write_reg(CFG_CLEAR_HITS, 32'(RST_CLEAR_HITS));
                    write_reg(CFG_WINDOW, 65535);
                end
                1:
                begin
                    write_reg(CFG_NEAR_LIMIT, $urandom_range(200, 800));
                    write_reg(CFG_MID_LIMIT, $urandom_range(800, 1600));
                    write_reg(CFG_FAR_LIMIT, $urandom_range(1600, 3000));
                    write_reg(CFG_ARM_HITS, 0);
                    write_reg(CFG_CLEAR_HITS, 16);
                    write_reg(CFG_WINDOW, 0);
                end
                2:
                begin
                    write_reg(CFG_NEAR_LIMIT, $urandom_range(0, 65535));
                    write_reg(CFG_MID_LIMIT, $urandom_range(0, 65535));
                    write_reg(CFG_FAR_LIMIT, $urandom_range(0, 65535));
                    // An arm threshold above the zone count never arms.
                    write_reg(CFG_ARM_HITS, 16);
                    write_reg(CFG_CLEAR_HITS, 0);
                    write_reg(CFG_WINDOW, $urandom_range(500, 3000));
                    // Writes to undecoded indexes must change nothing.
                    write_reg(CFG_SPARE_LO, $urandom_range(0, 65535));
                    write_reg(CFG_SPARE_HI, $urandom_range(0, 65535));
                end
                3:
                begin
                    write_reg(CFG_NEAR_LIMIT, $urandom_range(100, 700));
                    write_reg(CFG_MID_LIMIT, $urandom_range(700, 1400));
                    write_reg(CFG_FAR_LIMIT, $urandom_range(1400, 2500));
                    write_reg(CFG_ARM_HITS, $urandom_range(1, SCAN_ZONES));
                    write_reg(CFG_CLEAR_HITS, $urandom_range(0, arm_level));
                    write_reg(CFG_WINDOW, $urandom_range(50, 400));
                end
                4:
                begin
                    write_reg(CFG_NEAR_LIMIT, $urandom_range(0, 65535));
                    write_reg(CFG_MID_LIMIT, $urandom_range(0, 65535));
                    write_reg(CFG_FAR_LIMIT, $urandom_range(0, 65535));
                    write_reg(CFG_ARM_HITS, $urandom_range(0, 16));
                    write_reg(CFG_CLEAR_HITS, $urandom_range(0, 16));
                    write_reg(CFG_WINDOW, $urandom_range(0, 65535));
                end
                default:
                begin
                    write_reg(CFG_NEAR_LIMIT, 32'(RST_NEAR_LIMIT));
                    write_reg(CFG_MID_LIMIT, 32'(RST_MID_LIMIT));
                    write_reg(CFG_FAR_LIMIT, 32'(RST_FAR_LIMIT));
                    write_reg(CFG_ARM_HITS, 32'(RST_ARM_HITS));
                    write_reg(CFG_CLEAR_HITS, 32'(RST_CLEAR_HITS));
                    write_reg(CFG_WINDOW, 32'(RST_WINDOW));
                end
            endcase

            // Sender barely idles while the receiver mostly stalls, then the
            // reverse, then full rate on both sides.
            case (phase / 2)
                0:
                begin
                    tx_idle_pct  = 6;
                    rx_stall_pct = 84;
                end
                1:
                begin
                    tx_idle_pct  = 84;
                    rx_stall_pct = 6;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase

            // Scan spacing follows the window so both detections and expiries occur.
            step_ms = int'(window_span) / (SCAN_ZONES * 2) + 1;
            scans_queued = 0;
            while (scans_queued < SCANS_PER_PHASE)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_scan(0, 0, 1'b1);
                else
                    queue_passage();
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("tof_zone_passage_detector verification clean");
        else
            $display("tof_zone_passage_detector verification failed");
        $finish;
    end

endmodule
